// ===== rtl/ale_pkg.sv =====
// ----------------------------------------------------------------------------
// Array list engine package
// Field widths, action and status codes, and the control and status
// groups passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package ale_pkg;

  localparam int ACT_W        = 3;
  localparam int IDX_W        = 6;
  localparam int DATA_W       = 32;
  localparam int STAT_W       = 2;
  localparam int COUNT_W      = 6;
  localparam int DEF_CAPACITY = 32;
  localparam int RESULT_LIMIT = 32;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH   = 3'd0,
    ACT_POP    = 3'd1,
    ACT_INSERT = 3'd2,
    ACT_REMOVE = 3'd3,
    ACT_DUMP   = 3'd4
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADIDX = 2'd3
  } status_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic step;
    logic commit;
    logic dump;
    logic respond;
  } cmd_t;

  typedef struct packed {
    logic need_shift;
    logic need_dump;
    logic shift_done;
    logic dump_done;
    logic out_free;
  } stat_t;

endpackage

// ===== rtl/ale_if.sv =====
// ----------------------------------------------------------------------------
// Array list engine channels
// Request and result channels with valid/ready handshake and payload.
// ----------------------------------------------------------------------------
interface ale_in_if;
  import ale_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [ACT_W-1:0]         action;
  logic [IDX_W-1:0]         index;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output action, output index, output value, input ready);
  modport sink   (input valid, input action, input index, input value, output ready);
endinterface

interface ale_out_if;
  import ale_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic signed [DATA_W-1:0] data;
  logic [COUNT_W-1:0]       count;
  logic                     last;

  modport source (output valid, output status, output data, output count, output last,
                  input ready);
  modport sink   (input valid, input status, input data, input count, input last,
                  output ready);
endinterface

// ===== rtl/array_list_engine.sv =====
// ----------------------------------------------------------------------------
// Array list engine
// Ordered list of signed 32-bit words with push, pop, insert, remove and
// dump, held in a fixed-capacity single-port-pair store.
//
// Requests arrive as beats on in_ch (action, index, value); results leave
// as beats on out_ch (status, data, count, last). One request is worked on
// at a time; in_ch.ready is high while the engine is idle, even when a
// result beat is still waiting in the output register.
// Push, pop, errors and unused actions: the request is latched, evaluated
// and committed, then one result beat is sent. Insert moves the elements
// from the index up and remove the elements above the index, one per cycle,
// between evaluation and commit. Dump reads one element per cycle while
// out_ch takes the beats, at most 32 beats, the final one with last set.
// A stalled out_ch holds the current beat and pauses the walk of a dump or
// the final beat of any other request until the beat is taken.
// Reset clears the count and the output valid flag; the store is not
// cleared, only entries below the count are ever read.
// ----------------------------------------------------------------------------
module array_list_engine #(
  parameter int CAPACITY = ale_pkg::DEF_CAPACITY
) (
  input  logic       clk,
  input  logic       rst_n,
  ale_in_if.sink     in_ch,
  ale_out_if.source  out_ch
);
  import ale_pkg::*;

  cmd_t  cmd;
  stat_t st;
  logic  in_ready;

  assign in_ch.ready = in_ready;

  ale_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  ale_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_action (in_ch.action),
    .in_index  (in_ch.index),
    .in_value  (in_ch.value),
    .cmd       (cmd),
    .st        (st),
    .out_ch    (out_ch)
  );

endmodule

// ===== rtl/ale_ctrl.sv =====
// ----------------------------------------------------------------------------
// Array list engine controller
// Sequences one request: latch, evaluate, then an optional shift walk, commit
// and result beat, or a dump walk.
// ----------------------------------------------------------------------------
module ale_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  ale_pkg::stat_t st,
  output ale_pkg::cmd_t  cmd
);
  import ale_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_SHIFT,
    S_COMMIT,
    S_DUMP,
    S_RESP
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        priority if (st.need_shift) begin
          state_nxt = S_SHIFT;
        end else if (st.need_dump) begin
          state_nxt = S_DUMP;
        end else begin
          state_nxt = S_COMMIT;
        end
      end
      S_SHIFT: begin
        cmd.step = 1'b1;
        if (st.shift_done) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_RESP;
      end
      S_DUMP: begin
        cmd.dump = 1'b1;
        if (st.dump_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_RESP: begin
        cmd.respond = 1'b1;
        if (st.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/ale_dpath.sv =====
// ----------------------------------------------------------------------------
// Array list engine datapath
// Element store, count, request latch, shift and dump walk, and the
// result register.
// ----------------------------------------------------------------------------
module ale_dpath #(
  parameter int CAPACITY = ale_pkg::DEF_CAPACITY
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [ale_pkg::ACT_W-1:0]        in_action,
  input  logic [ale_pkg::IDX_W-1:0]        in_index,
  input  logic signed [ale_pkg::DATA_W-1:0] in_value,
  input  ale_pkg::cmd_t                    cmd,
  output ale_pkg::stat_t                   st,
  ale_out_if.source                        out_ch
);
  import ale_pkg::*;

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  logic signed [DATA_W-1:0] mem [CAPACITY];

  logic [ACT_W-1:0]         act_r;
  logic [IDX_W-1:0]         idx_r;
  logic signed [DATA_W-1:0] val_r;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [CNT_W-1:0]         rem_r, rem_nxt;
  logic [ADDR_W-1:0]        ptr_r, ptr_nxt;
  logic [ADDR_W-1:0]        raddr_q_r;
  logic signed [DATA_W-1:0] rd_data_r;
  logic                     mv_r, mv_nxt;
  logic                     dv_r, dv_nxt;
  status_t                  st_r;
  status_t                  status_c;

  logic                     out_valid_r, out_valid_nxt;
  status_t                  out_status_r;
  logic signed [DATA_W-1:0] out_data_r;
  logic [COUNT_W-1:0]       out_count_r;
  logic                     out_last_r;

  logic                     rd_en;
  logic [ADDR_W-1:0]        rd_addr;
  logic                     wr_en;
  logic [ADDR_W-1:0]        wr_addr;
  logic signed [DATA_W-1:0] wr_data;
  logic                     can_load;
  logic                     load_out;
  status_t                  load_status;
  logic signed [DATA_W-1:0] load_data;
  logic                     load_last;
  logic                     is_ins;
  logic                     full_c;
  logic                     empty_c;
  logic [CMP_W-1:0]         idx_e;
  logic [CMP_W-1:0]         cnt_e;

  assign idx_e    = CMP_W'(idx_r);
  assign cnt_e    = CMP_W'(cnt_r);
  assign full_c   = (cnt_r == CNT_W'(CAPACITY));
  assign empty_c  = (cnt_r == '0);
  assign is_ins   = (act_r == ACT_INSERT);
  assign can_load = !out_valid_r || out_ch.ready;

  always_comb begin
    status_c = ST_OK;
    case (act_r)
      ACT_PUSH: begin
        if (full_c) status_c = ST_FULL;
      end
      ACT_POP: begin
        if (empty_c) status_c = ST_EMPTY;
      end
      ACT_INSERT: begin
        priority if (full_c) begin
          status_c = ST_FULL;
        end else if (idx_e > cnt_e) begin
          status_c = ST_BADIDX;
        end
      end
      ACT_REMOVE: begin
        priority if (empty_c) begin
          status_c = ST_EMPTY;
        end else if (idx_e >= cnt_e) begin
          status_c = ST_BADIDX;
        end
      end
      ACT_DUMP: begin
        if (empty_c) status_c = ST_EMPTY;
      end
      default: begin
        status_c = ST_OK;
      end
    endcase
  end

  always_comb begin
    st.need_shift = (status_c == ST_OK) && ((act_r == ACT_INSERT) || (act_r == ACT_REMOVE));
    st.need_dump  = (act_r == ACT_DUMP) && !empty_c;
    st.shift_done = (rem_r == '0) && !mv_r;
    st.dump_done  = dv_r && can_load && (rem_r == '0);
    st.out_free   = can_load;
  end

  always_comb begin
    cnt_nxt     = cnt_r;
    rem_nxt     = rem_r;
    ptr_nxt     = ptr_r;
    mv_nxt      = mv_r;
    dv_nxt      = dv_r;
    rd_en       = 1'b0;
    rd_addr     = ptr_r;
    wr_en       = 1'b0;
    wr_addr     = ptr_r;
    wr_data     = rd_data_r;
    load_out    = 1'b0;
    load_status = st_r;
    load_data   = '0;
    load_last   = 1'b1;

    if (cmd.eval) begin
      mv_nxt = 1'b0;
      dv_nxt = 1'b0;
      if (is_ins) begin
        rem_nxt = cnt_r - CNT_W'(idx_r);
        ptr_nxt = ADDR_W'(cnt_r - CNT_W'(1));
      end else if (act_r == ACT_REMOVE) begin
        rem_nxt = cnt_r - CNT_W'(idx_r) - CNT_W'(1);
        ptr_nxt = ADDR_W'(idx_r + IDX_W'(1));
      end else begin
        rem_nxt = (int'(cnt_r) > RESULT_LIMIT) ? CNT_W'(RESULT_LIMIT) : cnt_r;
        ptr_nxt = '0;
      end
    end

    if (cmd.step) begin
      mv_nxt = 1'b0;
      if (rem_r != '0) begin
        rd_en   = 1'b1;
        ptr_nxt = is_ins ? ptr_r - ADDR_W'(1) : ptr_r + ADDR_W'(1);
        rem_nxt = rem_r - CNT_W'(1);
        mv_nxt  = 1'b1;
      end
      if (mv_r) begin
        wr_en   = 1'b1;
        wr_addr = is_ins ? raddr_q_r + ADDR_W'(1) : raddr_q_r - ADDR_W'(1);
        wr_data = rd_data_r;
      end
    end

    if (cmd.commit && (st_r == ST_OK)) begin
      case (act_r)
        ACT_PUSH: begin
          wr_en   = 1'b1;
          wr_addr = ADDR_W'(cnt_r);
          wr_data = val_r;
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        ACT_POP: begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
        ACT_INSERT: begin
          wr_en   = 1'b1;
          wr_addr = ADDR_W'(idx_r);
          wr_data = val_r;
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        ACT_REMOVE: begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
        default: begin
          cnt_nxt = cnt_r;
        end
      endcase
    end

    if (cmd.dump) begin
      if (dv_r && can_load) begin
        load_out    = 1'b1;
        load_status = ST_OK;
        load_data   = rd_data_r;
        load_last   = (rem_r == '0);
        dv_nxt      = 1'b0;
      end
      if ((rem_r != '0) && (!dv_r || can_load)) begin
        rd_en   = 1'b1;
        ptr_nxt = ptr_r + ADDR_W'(1);
        rem_nxt = rem_r - CNT_W'(1);
        dv_nxt  = 1'b1;
      end
    end

    if (cmd.respond && can_load) begin
      load_out    = 1'b1;
      load_status = st_r;
      load_data   = '0;
      load_last   = 1'b1;
    end

    out_valid_nxt = load_out ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      raddr_q_r <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      rem_r       <= '0;
      mv_r        <= 1'b0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      rem_r       <= rem_nxt;
      mv_r        <= mv_nxt;
      dv_r        <= dv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    if (cmd.load) begin
      act_r <= in_action;
      idx_r <= in_index;
      val_r <= in_value;
    end
    if (cmd.eval) begin
      st_r <= status_c;
    end
    if (load_out) begin
      out_status_r <= load_status;
      out_data_r   <= load_data;
      out_count_r  <= COUNT_W'(cnt_r);
      out_last_r   <= load_last;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.data   = out_data_r;
  assign out_ch.count  = out_count_r;
  assign out_ch.last   = out_last_r;

endmodule

// ===== bench/tb_array_list_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Array list engine testbench
// Sends push, pop, insert, remove, dump and spare-code requests with random
// gaps and result back-pressure. Works out the list contents alongside the
// engine and compares every result beat, field by field, in order.
// ----------------------------------------------------------------------------
module tb_array_list_engine;
  import ale_pkg::*;

  localparam int CAP            = DEF_CAPACITY;
  localparam int N_RANDOM       = 50;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int TAIL_CYCLES    = 60;
  localparam int MAX_REPORTS    = 10;

  localparam logic [ACT_W-1:0] ACT_SPARE_A = 3'd5;
  localparam logic [ACT_W-1:0] ACT_SPARE_B = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE_C = 3'd7;

  typedef struct packed {
    status_t                  status;
    logic signed [DATA_W-1:0] data;
    logic [COUNT_W-1:0]       count;
    logic                     last;
  } result_beat_t;

  typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIX} req_mix_t;

  class list_scoreboard;
    logic signed [DATA_W-1:0] elems [CAP];
    int unsigned              n_elems = 0;
    result_beat_t             pending [$];
    int                       mismatches = 0;

    function void queue_beat(status_t st, logic signed [DATA_W-1:0] d, logic lst);
      result_beat_t b;
      b.status = st;
      b.data   = d;
      b.count  = COUNT_W'(n_elems);
      b.last   = lst;
      pending.push_back(b);
    endfunction

    function void note_request(logic [ACT_W-1:0] act, logic [IDX_W-1:0] idx,
                               logic signed [DATA_W-1:0] val);
      status_t     st;
      int unsigned k;
      int unsigned n;
      st = ST_OK;
      case (act)
        ACT_PUSH: begin
          if (n_elems >= CAP) st = ST_FULL;
          else begin
            elems[n_elems] = val;
            n_elems++;
          end
        end
        ACT_POP: begin
          if (n_elems == 0) st = ST_EMPTY;
          else n_elems--;
        end
        ACT_INSERT: begin
          if (n_elems >= CAP) st = ST_FULL;
          else if (idx > n_elems) st = ST_BADIDX;
          else begin
            for (k = n_elems; k > idx; k--) elems[k] = elems[k-1];
            elems[idx] = val;
            n_elems++;
          end
        end
        ACT_REMOVE: begin
          if (n_elems == 0) st = ST_EMPTY;
          else if (idx >= n_elems) st = ST_BADIDX;
          else begin
            for (k = idx; k + 1 < n_elems; k++) elems[k] = elems[k+1];
            n_elems--;
          end
        end
        ACT_DUMP: begin
          if (n_elems == 0) queue_beat(ST_EMPTY, '0, 1'b1);
          else begin
            n = (n_elems > RESULT_LIMIT) ? RESULT_LIMIT : n_elems;
            for (k = 0; k < n; k++) queue_beat(ST_OK, elems[k], k + 1 == n);
          end
          return;
        end
        default: ;
      endcase
      queue_beat(st, '0, 1'b1);
    endfunction

    function void flag(string what, result_beat_t want, result_beat_t got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display({"%0t: %s: expected status=%0d data=%0d count=%0d last=%0b,",
                  " got status=%0d data=%0d count=%0d last=%0b"},
                 $realtime, what, want.status, want.data, want.count, want.last,
                 got.status, got.data, got.count, got.last);
    endfunction

    function void check_result(result_beat_t got);
      result_beat_t want;
      if (pending.size() == 0) begin
        flag("result beat with nothing pending", '0, got);
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status || got.data !== want.data ||
          got.count !== want.count || got.last !== want.last)
        flag("result mismatch", want, got);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   hold_wanted = 1'b0;
  bit   hold_done   = 1'b0;
  bit   quiet       = 1'b0;
  int   idle_cycles = 0;

  ale_in_if  in_ch ();
  ale_out_if out_ch ();

  list_scoreboard sb = new();

  always #10 clk = ~clk;

  array_list_engine #(.CAPACITY(CAP)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // result monitor and watchdog
  always @(posedge clk) begin
    result_beat_t got;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.status = status_t'(out_ch.status);
        got.data   = out_ch.data;
        got.count  = out_ch.count;
        got.last   = out_ch.last;
        sb.check_result(got);
      end
      if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // result side ready: random stalls, one long hold-off
  initial begin
    forever begin
      if (hold_wanted && !hold_done) begin
        hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ch.ready <= quiet || ($urandom_range(0, 99) >= 14);
        @(posedge clk);
      end
    end
  end

  task automatic send_req(input logic [ACT_W-1:0] act, input logic [IDX_W-1:0] idx,
                          input logic signed [DATA_W-1:0] val);
    in_ch.valid  <= 1'b1;
    in_ch.action <= act;
    in_ch.index  <= idx;
    in_ch.value  <= val;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_request(act, idx, val);
  endtask

  task automatic gap();
    if (!quiet && $urandom_range(0, 99) < 14) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic drain_wait();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
  endtask

  function automatic logic signed [DATA_W-1:0] rand_value();
    case ($urandom_range(0, 15))
      0:       return {1'b1, {(DATA_W-1){1'b0}}};
      1:       return {1'b0, {(DATA_W-1){1'b1}}};
      2:       return '1;
      3:       return '0;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random(input req_mix_t mode);
    int unsigned      r;
    int unsigned      n;
    int unsigned      t_push, t_pop, t_ins, t_rem, t_dump;
    logic [ACT_W-1:0] act;
    logic [IDX_W-1:0] idx;
    n = sb.n_elems;
    r = $urandom_range(0, 99);
    case (mode)
      MODE_FILL: begin
        t_push = 45; t_pop = 50; t_ins = 78; t_rem = 84; t_dump = 94;
      end
      MODE_DRAIN: begin
        t_push = 12; t_pop = 42; t_ins = 50; t_rem = 82; t_dump = 94;
      end
      default: begin
        t_push = 22; t_pop = 38; t_ins = 58; t_rem = 74; t_dump = 94;
      end
    endcase
    if (r < t_push) act = ACT_PUSH;
    else if (r < t_pop) act = ACT_POP;
    else if (r < t_ins) act = ACT_INSERT;
    else if (r < t_rem) act = ACT_REMOVE;
    else if (r < t_dump) act = ACT_DUMP;
    else begin
      case ($urandom_range(0, 2))
        0:       act = ACT_SPARE_A;
        1:       act = ACT_SPARE_B;
        default: act = ACT_SPARE_C;
      endcase
    end
    if ($urandom_range(0, 9) == 0) idx = IDX_W'($urandom);
    else if (act == ACT_INSERT) idx = IDX_W'($urandom_range(0, n));
    else if (act == ACT_REMOVE && n > 0) idx = IDX_W'($urandom_range(0, n - 1));
    else idx = IDX_W'($urandom);
    send_req(act, idx, rand_value());
  endtask

  initial begin
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.action <= ACT_PUSH;
    in_ch.index  <= '0;
    in_ch.value  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    send_req(ACT_POP, '0, '0);
    send_req(ACT_REMOVE, '0, '0);
    send_req(ACT_DUMP, '0, '0);
    send_req(ACT_INSERT, 6'd1, 32'sd5);
    send_req(ACT_INSERT, '0, {1'b1, {(DATA_W-1){1'b0}}});
    send_req(ACT_PUSH, '1, {1'b0, {(DATA_W-1){1'b1}}});
    send_req(ACT_PUSH, '0, '1);
    send_req(ACT_INSERT, 6'd3, '0);
    send_req(ACT_INSERT, 6'd1, 32'h5a5a_a5a5);
    send_req(ACT_INSERT, 6'd6, 32'sd1);
    send_req(ACT_REMOVE, 6'd5, '0);
    send_req(ACT_REMOVE, 6'd4, '0);
    send_req(ACT_REMOVE, '0, '0);
    send_req(ACT_REMOVE, '1, '0);
    send_req(ACT_INSERT, '1, '0);
    send_req(ACT_SPARE_A, 6'h2a, 32'h1234_5678);
    send_req(ACT_SPARE_B, 6'h15, '1);
    send_req(ACT_SPARE_C, '1, '0);
    send_req(ACT_DUMP, '0, '0);
    send_req(ACT_POP, '0, '0);

    // fill to capacity, then hit the full cases
    while (sb.n_elems < CAP) begin
      gap();
      if ($urandom_range(0, 1)) send_req(ACT_PUSH, IDX_W'($urandom), rand_value());
      else send_req(ACT_INSERT, IDX_W'($urandom_range(0, sb.n_elems)), rand_value());
    end
    send_req(ACT_PUSH, IDX_W'($urandom), rand_value());
    send_req(ACT_INSERT, IDX_W'($urandom), rand_value());
    send_req(ACT_INSERT, '0, rand_value());
    send_req(ACT_DUMP, '0, '0);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 10) hold_wanted = 1'b1;
      if (i == 25) drain_wait();
      quiet = (i >= 30 && i < 43);
      gap();
      send_random(i < 12 ? MODE_MIX : i < 25 ? MODE_DRAIN : i < 38 ? MODE_FILL : MODE_MIX);
    end

    drain_wait();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
